FILE: design/bkce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkce_pkg
// Shared types and constants of the bezier keyframe curve evaluator.
// ----------------------------------------------------------------------------
package bkce_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int D_W        = 32;
  localparam int FC_W       = 7;
  localparam int STEP_W     = 5;
  localparam int DIV_LAST   = 16;
  localparam int MUL_LAST   = 10;
  localparam int PADDR_W    = 3;

  // request modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_ADV  = 2'd2;

  // register indexes
  localparam logic [PADDR_W-3:0] REG_FRAME_COUNT = '0;

  typedef struct packed {
    logic [1:0]              mode;
    logic [5:0]              frame_index;
    logic signed [D_W-1:0]   key_x;
    logic signed [D_W-1:0]   key_y;
    logic signed [D_W-1:0]   handle_in_y;
    logic signed [D_W-1:0]   handle_out_y;
    logic signed [D_W-1:0]   time_or_delta;
  } in_req_t;

  typedef struct packed {
    logic signed [D_W-1:0]   curve_value;
    logic                    segment_hit;
    logic signed [D_W-1:0]   current_time;
  } out_rsp_t;

  // one keyframe as kept in memory
  typedef struct packed {
    logic signed [D_W-1:0]   out_y;
    logic signed [D_W-1:0]   in_y;
    logic signed [D_W-1:0]   y;
    logic signed [D_W-1:0]   x;
  } key_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD,
    OP_CMP,
    OP_DIV,
    OP_MUL,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [IDX_W-1:0]    addr;
    logic [STEP_W-1:0]   step;
  } dp_cmd_t;

  typedef struct packed {
    logic                hit;
  } dp_status_t;

endpackage

FILE: design/bezier_keyframe_curve_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_keyframe_curve_eval
// One cubic bezier keyframe curve in Q16.16 with an APB frame count register.
// ----------------------------------------------------------------------------
// A load request goes straight from accept to its response. A time request
// walks the keyframes, when at least two are in use, with one memory read and
// one compare per frame; a hit on segment k adds a serial divide and an
// 11-step weight and multiply-accumulate pass. One request is in flight at a
// time; a finished response waits in the output register while the next
// request is already being worked on.
module bezier_keyframe_curve_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bkce_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bkce_pkg::out_rsp_t            out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bkce_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bkce_pkg::*;

  logic [FC_W-1:0] frame_count_q;
  dp_cmd_t         cmd;
  dp_status_t      status;
  logic            reg_sel;

  // frame count register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_FRAME_COUNT);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      frame_count_q <= pwdata[FC_W-1:0];
    end
  end
  assign prdata = reg_sel ? {{(32-FC_W){1'b0}}, frame_count_q} : 32'd0;

  bkce_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_mode_i     (in_req_i.mode),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_count_i (frame_count_q),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  bkce_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .status_o  (status),
    .out_rsp_o (out_rsp_o)
  );

`ifndef NO_ASSERTIONS
  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  // a stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("response changed while stalled");

  // a load request never reports a segment hit
  a_load_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.mode == MODE_LOAD) |=> ##1
      (!out_valid_o || !out_rsp_o.segment_hit || !$rose(out_valid_o)))
    else $error("hit reported for a load request");
`endif

endmodule

FILE: design/bkce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkce_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bkce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bkce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkce_datapath
// Keyframe memory, animation time, serial divider and bezier weight/MAC unit.
// ----------------------------------------------------------------------------
module bkce_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bkce_pkg::dp_cmd_t   cmd_i,
  input  bkce_pkg::in_req_t   in_req_i,
  output bkce_pkg::dp_status_t status_o,
  output bkce_pkg::out_rsp_t  out_rsp_o
);
  import bkce_pkg::*;

  logic signed [D_W-1:0] time_q, time_d;
  logic signed [D_W-1:0] held_q;
  logic                  hit_q;
  key_t                  prev_q;
  key_t                  cur;
  key_t                  wkey;
  logic                  we;
  logic signed [D_W-1:0] p_q [4];
  logic [D_W:0]          r_q;
  logic [D_W-1:0]        dx_q;
  logic                  dxz_q;
  logic [16:0]           q_q;
  logic [32:0]           uu_q, tt_q;
  logic [24:0]           w_q [4];
  logic signed [59:0]    acc_q;
  out_rsp_t              out_q;

  logic signed [D_W:0]   tsum;
  logic signed [D_W:0]   num_w, dx_w;
  logic                  hit_w;
  logic [D_W:0]          rs;
  logic                  ge;
  logic [16:0]           t_w, u_w;
  logic [33:0]           mul_a;
  logic [16:0]           mul_b;
  logic [50:0]           mul_p;
  logic [52:0]           mul_p3;
  logic signed [25:0]    mac_w;
  logic signed [D_W-1:0] mac_p;
  logic signed [57:0]    mac_prod;
  logic signed [59:0]    rnd;
  logic signed [35:0]    shv;
  logic signed [D_W-1:0] sat_v;

  // keyframe memory
  assign we = (cmd_i.op == OP_ACCEPT) && (in_req_i.mode == MODE_LOAD);
  assign wkey = '{out_y: in_req_i.handle_out_y, in_y: in_req_i.handle_in_y,
                  y: in_req_i.key_y, x: in_req_i.key_x};

  bkce_ram #(
    .WIDTH($bits(key_t)),
    .DEPTH(MAX_FRAMES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_req_i.frame_index[IDX_W-1:0]),
    .wdata_i (wkey),
    .raddr_i (cmd_i.addr),
    .rdata_o (cur)
  );

  // time update with saturation
  always_comb begin
    tsum   = '0;
    time_d = time_q;
    if (in_req_i.mode == MODE_SET) begin
      time_d = in_req_i.time_or_delta;
    end else if (in_req_i.mode == MODE_ADV) begin
      tsum = {time_q[D_W-1], time_q} +
             {in_req_i.time_or_delta[D_W-1], in_req_i.time_or_delta};
      if (tsum[D_W] != tsum[D_W-1]) begin
        time_d = tsum[D_W] ? {1'b1, {(D_W-1){1'b0}}} : {1'b0, {(D_W-1){1'b1}}};
      end else begin
        time_d = tsum[D_W-1:0];
      end
    end
  end

  // segment compare
  assign hit_w = (time_q >= prev_q.x) && (time_q <= cur.x);
  assign num_w = {time_q[D_W-1], time_q} - {prev_q.x[D_W-1], prev_q.x};
  assign dx_w  = {cur.x[D_W-1], cur.x} - {prev_q.x[D_W-1], prev_q.x};
  assign status_o.hit = hit_w;

  // restoring divide step
  assign rs = (cmd_i.step == '0) ? r_q : {r_q[D_W-1:0], 1'b0};
  assign ge = rs >= {1'b0, dx_q};

  // shared weight multiplier
  assign t_w = dxz_q ? 17'd0 : q_q;
  assign u_w = 17'h10000 - t_w;
  always_comb begin
    mul_a = {17'd0, u_w};
    mul_b = u_w;
    case (cmd_i.step)
      5'd1: begin
        mul_a = {17'd0, t_w};
        mul_b = t_w;
      end
      5'd2: begin
        mul_a = {1'b0, uu_q};
        mul_b = u_w;
      end
      5'd3: begin
        mul_a = {1'b0, uu_q};
        mul_b = t_w;
      end
      5'd4: begin
        mul_a = {1'b0, tt_q};
        mul_b = u_w;
      end
      5'd5: begin
        mul_a = {1'b0, tt_q};
        mul_b = t_w;
      end
      default: begin
        mul_a = {17'd0, u_w};
        mul_b = u_w;
      end
    endcase
  end
  assign mul_p  = 51'(mul_a * mul_b);
  assign mul_p3 = {mul_p, 1'b0} + {2'b00, mul_p};

  // weight times control point
  always_comb begin
    case (cmd_i.step)
      5'd7: begin
        mac_w = $signed({1'b0, w_q[1]});
        mac_p = p_q[1];
      end
      5'd8: begin
        mac_w = $signed({1'b0, w_q[2]});
        mac_p = p_q[2];
      end
      5'd9: begin
        mac_w = $signed({1'b0, w_q[3]});
        mac_p = p_q[3];
      end
      default: begin
        mac_w = $signed({1'b0, w_q[0]});
        mac_p = p_q[0];
      end
    endcase
  end
  assign mac_prod = mac_w * mac_p;

  // round, floor shift and saturate
  assign rnd = acc_q + 60'sd8388608;
  assign shv = 36'(rnd >>> 24);
  always_comb begin
    if (shv > 36'sd2147483647) begin
      sat_v = {1'b0, {(D_W-1){1'b1}}};
    end else if (shv < -36'sd2147483648) begin
      sat_v = {1'b1, {(D_W-1){1'b0}}};
    end else begin
      sat_v = shv[D_W-1:0];
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      held_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_ACCEPT: begin
          time_q <= time_d;
          hit_q  <= 1'b0;
        end
        OP_CMP: begin
          if (cmd_i.addr != '0 && hit_w) begin
            hit_q <= 1'b1;
          end
        end
        OP_MUL: begin
          if (cmd_i.step == 5'(MUL_LAST)) begin
            held_q <= sat_v;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CMP: begin
        prev_q <= cur;
        if (hit_w) begin
          p_q[0] <= prev_q.y;
          p_q[1] <= prev_q.out_y;
          p_q[2] <= cur.in_y;
          p_q[3] <= cur.y;
          r_q    <= {1'b0, num_w[D_W-1:0]};
          dx_q   <= dx_w[D_W-1:0];
          dxz_q  <= (dx_w == '0);
          q_q    <= '0;
        end
      end
      OP_DIV: begin
        q_q <= {q_q[15:0], ge};
        r_q <= ge ? (rs - {1'b0, dx_q}) : rs;
      end
      OP_MUL: begin
        case (cmd_i.step)
          5'd0: begin
            uu_q  <= mul_p[32:0];
            acc_q <= '0;
          end
          5'd1: tt_q   <= mul_p[32:0];
          5'd2: w_q[0] <= mul_p[48:24];
          5'd3: w_q[1] <= mul_p3[48:24];
          5'd4: w_q[2] <= mul_p3[48:24];
          5'd5: w_q[3] <= mul_p[48:24];
          5'd6, 5'd7, 5'd8, 5'd9: acc_q <= acc_q + 60'(mac_prod);
          default: begin
          end
        endcase
      end
      OP_EMIT: begin
        out_q.curve_value  <= held_q;
        out_q.segment_hit  <= hit_q;
        out_q.current_time <= time_q;
      end
      default: begin
      end
    endcase
  end

  assign out_rsp_o = out_q;

endmodule

FILE: design/bkce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkce_ctrl
// Sequencer: request accept, segment search, divide, weights, response.
// ----------------------------------------------------------------------------
module bkce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_mode_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [bkce_pkg::FC_W-1:0] frame_count_i,
  input  bkce_pkg::dp_status_t status_i,
  output bkce_pkg::dp_cmd_t    cmd_o
);
  import bkce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DIV,
    S_MUL,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  addr_q, addr_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  n_w;
  logic              accept;

  // frames in use, capped at the memory depth
  assign n_w = (frame_count_i > FC_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                   : CNT_W'(frame_count_i);
  assign accept = in_valid_i && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.addr  = addr_q[IDX_W-1:0];
    cmd_o.step  = step_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_ACCEPT;
          addr_d   = '0;
          if ((in_mode_i == MODE_SET || in_mode_i == MODE_ADV) && n_w >= CNT_W'(2)) begin
            state_d = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_RD: begin
        cmd_o.op = OP_RD;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        if (addr_q != '0 && status_i.hit) begin
          step_d  = '0;
          state_d = S_DIV;
        end else if (addr_q + CNT_W'(1) == n_w) begin
          state_d = S_FIN;
        end else begin
          addr_d  = addr_q + CNT_W'(1);
          state_d = S_RD;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (step_q == STEP_W'(DIV_LAST)) begin
          step_d  = '0;
          state_d = S_MUL;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        if (step_q == STEP_W'(MUL_LAST)) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
